@@ rtl/cpd_pkg.sv @@
`timescale 1ns / 1ps
package cpd_pkg;

   localparam int unsigned CNT_W  = 16;
   localparam int unsigned ROOT_W = 32;
   localparam int unsigned QUOT_W = 63;

   localparam logic [CNT_W-1:0] OFFSET_MARGIN = 16'd50;
   localparam logic [CNT_W-1:0] MIN_FLOOR     = 16'd100;

   localparam logic [CNT_W-1:0] RST_MIN  = 16'd100;
   localparam logic [CNT_W-1:0] RST_MAX  = 16'd65535;
   localparam logic [CNT_W-1:0] RST_PARK = 16'd20000;
   localparam logic [CNT_W-1:0] RST_DC   = 16'd50;
   localparam logic [CNT_W-1:0] FAR_DIST = 16'hFFFF;

   // 54612.5 in Q47.16 scaled by 2^31 for the reciprocal-root divide
   localparam logic [QUOT_W-1:0] SCALE_NUM   = 63'(64'd109225 << 46);
   // 10922.5 in Q47.16
   localparam logic [63:0]       OFFSET_BASE = 64'd715816960;
   // 65535.0 in Q47.16
   localparam logic [63:0]       FAR_OFFSET  = 64'd4294901760;

   typedef enum logic [1:0] {
      ITEM_SAMPLE  = 2'd0,
      ITEM_BEGIN   = 2'd1,
      ITEM_END     = 2'd2,
      ITEM_RESTORE = 2'd3
   } item_cmd_type;

   typedef enum logic [1:0] {
      REG_SAVED_MIN  = 2'd0,
      REG_SAVED_MAX  = 2'd1,
      REG_SAVED_PARK = 2'd2
   } reg_index_type;

   typedef enum logic [4:0] {
      DP_IDLE,
      DP_LOAD,
      DP_FAR,
      DP_RSQ_C,
      DP_RSQ_M,
      DP_SAVE_RM,
      DP_RSQ_P,
      DP_FIT_PREP,
      DP_DEGEN,
      DP_DIV,
      DP_SET_SF,
      DP_MUL0,
      DP_MUL1,
      DP_MUL2,
      DP_SET_SO,
      DP_SUM,
      DP_REPORT,
      DP_END_CAL,
      DP_OUT
   } dp_op_type;

   typedef struct packed {
      logic       rsq_done;
      logic       div_done;
      logic       near;
      logic       degen;
      logic       den_zero;
      logic [1:0] item_cmd;
      logic       out_free;
   } dp_status_type;

   typedef struct packed {
      logic [1:0]       command;
      logic [CNT_W-1:0] raw_count;
   } req_type;

   typedef struct packed {
      logic [CNT_W-1:0] distance;
      logic [CNT_W-1:0] echo_count;
      logic [CNT_W-1:0] report_min;
      logic [CNT_W-1:0] report_max;
      logic [CNT_W-1:0] report_park;
      logic             in_calibration;
   } rsp_type;

endpackage

@@ rtl/cpd_rsq.sv @@
`timescale 1ns / 1ps
// floor(2^31 / sqrt(x)): one result bit per cycle, largest r with r*r*x <= 2^62.
// Keeps r*r*x and r*x so each trial is shifts and adds only.
module cpd_rsq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [cpd_pkg::CNT_W-1:0]   x,
   output logic                        done,
   output logic [cpd_pkg::ROOT_W-1:0]  root
);

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  k_ff;
   logic [15:0] x_ff;
   logic [31:0] r_ff;
   logic [62:0] sq_ff;
   logic [47:0] rx_ff;
   logic [79:0] trial;
   logic        fits;

   // (r + 2^k)^2 x = r^2 x + r x 2^(k+1) + x 4^k
   assign trial = 80'(sq_ff) + (80'(rx_ff) << (7'(k_ff) + 7'd1)) + (80'(x_ff) << {k_ff, 1'b0});
   assign fits  = trial <= (80'd1 << 62);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         k_ff    <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            k_ff    <= 5'd31;
         end else if (busy_ff) begin
            k_ff <= k_ff - 5'd1;
            if (k_ff == 5'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff  <= x;
         r_ff  <= '0;
         sq_ff <= '0;
         rx_ff <= '0;
      end else if (busy_ff && fits) begin
         r_ff  <= r_ff | (32'd1 << k_ff);
         sq_ff <= trial[62:0];
         rx_ff <= rx_ff + (48'(x_ff) << k_ff);
      end
   end

   assign done = done_ff;
   assign root = r_ff;

endmodule

@@ rtl/cpd_div.sv @@
`timescale 1ns / 1ps
// Restoring divide of the fixed scale numerator, one quotient bit per cycle.
module cpd_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [31:0]                 divisor,
   output logic                        done,
   output logic [cpd_pkg::QUOT_W-1:0]  quot
);

   logic                        busy_ff;
   logic                        done_ff;
   logic [5:0]                  n_ff;
   logic [cpd_pkg::QUOT_W-1:0]  qd_ff;
   logic [31:0]                 dv_ff;
   logic [31:0]                 rem_ff;
   logic [32:0]                 rem_sh;
   logic [33:0]                 diff;
   logic                        take;

   assign rem_sh = {rem_ff, qd_ff[cpd_pkg::QUOT_W-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, dv_ff};
   assign take   = !diff[33];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         n_ff    <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            n_ff    <= 6'(cpd_pkg::QUOT_W - 1);
         end else if (busy_ff) begin
            n_ff <= n_ff - 6'd1;
            if (n_ff == 6'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         qd_ff  <= cpd_pkg::SCALE_NUM;
         dv_ff  <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= take ? diff[31:0] : rem_sh[31:0];
         qd_ff  <= {qd_ff[cpd_pkg::QUOT_W-2:0], take};
      end
   end

   assign done = done_ff;
   assign quot = qd_ff;

endmodule

@@ rtl/cpd_dp.sv @@
`timescale 1ns / 1ps
module cpd_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  cpd_pkg::dp_op_type       op,
   output cpd_pkg::dp_status_type   status,
   input  cpd_pkg::req_type         req_data,
   input  logic                     csr_we,
   input  logic [1:0]               csr_index,
   input  logic [15:0]              csr_wdata,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output cpd_pkg::rsp_type         rsp_data
);

   logic [15:0] saved_min_ff, saved_max_ff, saved_park_ff;
   logic [15:0] min_ff, max_ff, park_ff, last_ff, dc_ff;
   logic        cal_ff;
   logic        rsp_valid_ff;
   cpd_pkg::rsp_type rsp_data_ff;

   logic [1:0]         cmd_ff;
   logic signed [16:0] c_ff, m_ff, p_ff;
   logic [31:0]        rm_ff;
   logic [63:0]        sf_ff, so_ff;
   logic [63:0]        mul_ff;
   logic [95:0]        acc_ff;
   logic [15:0]        dist_ff, echo_ff, rep_min_ff, rep_max_ff, rep_park_ff;

   logic [15:0] min_ld, max_ld, park_ld;
   logic        cal_ld;
   logic [15:0] min_floor, dc_fit;
   logic signed [32:0] den, den_neg;
   logic [31:0] den_mag;
   logic [63:0] sf_mag, sf_new, p_mag, prod;
   logic [31:0] mul_a;
   logic [63:0] mul_p;
   logic [64:0] dsum;
   logic [15:0] dist_sum;

   logic                        rsq_start, rsq_done;
   logic [15:0]                 rsq_x;
   logic [cpd_pkg::ROOT_W-1:0]  root;
   logic                        div_start, div_done;
   logic [cpd_pkg::QUOT_W-1:0]  quot;

   // state after the item's own updates
   always_comb begin
      min_ld  = min_ff;
      max_ld  = max_ff;
      park_ld = park_ff;
      cal_ld  = cal_ff;
      case (req_data.command)
         cpd_pkg::ITEM_SAMPLE: begin
            if (cal_ff && req_data.raw_count < min_ff) min_ld = req_data.raw_count;
            if (cal_ff && req_data.raw_count > max_ff) max_ld = req_data.raw_count;
         end
         cpd_pkg::ITEM_BEGIN: begin
            min_ld  = last_ff;
            max_ld  = last_ff;
            park_ld = last_ff;
            cal_ld  = 1'b1;
         end
         cpd_pkg::ITEM_RESTORE: begin
            min_ld  = saved_min_ff;
            max_ld  = saved_max_ff;
            park_ld = saved_park_ff;
         end
         default: ;
      endcase
   end

   assign min_floor = (min_ff < cpd_pkg::MIN_FLOOR) ? cpd_pkg::MIN_FLOOR : min_ff;
   assign dc_fit    = (min_floor > cpd_pkg::OFFSET_MARGIN) ?
                      min_floor - cpd_pkg::OFFSET_MARGIN : '0;

   assign den     = $signed({1'b0, rm_ff}) - $signed({1'b0, root});
   assign den_neg = -den;
   assign den_mag = den[32] ? den_neg[31:0] : den[31:0];
   assign sf_new  = den[32] ? (64'd0 - {1'b0, quot}) : {1'b0, quot};

   // |scale| times root, 32 bits of the magnitude per pass
   assign sf_mag = sf_ff[63] ? (64'd0 - sf_ff) : sf_ff;
   assign mul_a  = (op == cpd_pkg::DP_MUL0) ? sf_mag[31:0] : sf_mag[63:32];
   assign mul_p  = mul_a * root;
   assign p_mag  = acc_ff[94:31];
   assign prod   = sf_ff[63] ? (64'd0 - p_mag) : p_mag;

   assign dsum     = {prod[63], prod} + {so_ff[63], so_ff};
   assign dist_sum = dsum[64] ? 16'd0 :
                     (dsum[63:32] != 32'd0) ? cpd_pkg::FAR_DIST : dsum[31:16];

   always_comb begin
      case (op)
         cpd_pkg::DP_RSQ_M: rsq_x = m_ff[15:0];
         cpd_pkg::DP_RSQ_P: rsq_x = p_ff[15:0];
         default:           rsq_x = c_ff[15:0];
      endcase
   end
   assign rsq_start = (op == cpd_pkg::DP_RSQ_C) || (op == cpd_pkg::DP_RSQ_M) ||
                      (op == cpd_pkg::DP_RSQ_P);
   assign div_start = (op == cpd_pkg::DP_DIV);

   cpd_rsq u_rsq (
      .clock (clock),
      .reset (reset),
      .start (rsq_start),
      .x     (rsq_x),
      .done  (rsq_done),
      .root  (root)
   );

   cpd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .divisor (den_mag),
      .done    (div_done),
      .quot    (quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         saved_min_ff  <= cpd_pkg::RST_MIN;
         saved_max_ff  <= cpd_pkg::RST_MAX;
         saved_park_ff <= cpd_pkg::RST_PARK;
         min_ff        <= cpd_pkg::RST_MIN;
         max_ff        <= cpd_pkg::RST_MAX;
         park_ff       <= cpd_pkg::RST_PARK;
         last_ff       <= '0;
         dc_ff         <= cpd_pkg::RST_DC;
         cal_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               cpd_pkg::REG_SAVED_MIN:  saved_min_ff  <= csr_wdata;
               cpd_pkg::REG_SAVED_MAX:  saved_max_ff  <= csr_wdata;
               cpd_pkg::REG_SAVED_PARK: saved_park_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (op == cpd_pkg::DP_OUT) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (op)
            cpd_pkg::DP_LOAD: begin
               min_ff  <= min_ld;
               max_ff  <= max_ld;
               park_ff <= park_ld;
               cal_ff  <= cal_ld;
               if (req_data.command == cpd_pkg::ITEM_SAMPLE) last_ff <= req_data.raw_count;
            end
            cpd_pkg::DP_FIT_PREP: begin
               min_ff <= min_floor;
               dc_ff  <= dc_fit;
            end
            cpd_pkg::DP_END_CAL: cal_ff <= 1'b0;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (op)
         cpd_pkg::DP_LOAD: begin
            cmd_ff      <= req_data.command;
            c_ff        <= $signed({1'b0, req_data.raw_count}) - $signed({1'b0, dc_ff});
            dist_ff     <= '0;
            echo_ff     <= (req_data.command == cpd_pkg::ITEM_SAMPLE) ?
                           req_data.raw_count : 16'd0;
            rep_min_ff  <= min_ld;
            rep_max_ff  <= max_ld;
            rep_park_ff <= park_ld;
         end
         cpd_pkg::DP_FIT_PREP: begin
            m_ff <= $signed({1'b0, min_floor}) - $signed({1'b0, dc_fit});
            p_ff <= $signed({1'b0, park_ff}) - $signed({1'b0, dc_fit});
         end
         cpd_pkg::DP_SAVE_RM: rm_ff <= root;
         cpd_pkg::DP_DEGEN: begin
            sf_ff <= '0;
            so_ff <= cpd_pkg::FAR_OFFSET;
         end
         cpd_pkg::DP_SET_SF: sf_ff <= sf_new;
         cpd_pkg::DP_MUL0:   mul_ff <= mul_p;
         cpd_pkg::DP_MUL1: begin
            acc_ff <= {32'd0, mul_ff};
            mul_ff <= mul_p;
         end
         cpd_pkg::DP_MUL2:   acc_ff <= acc_ff + {mul_ff, 32'd0};
         cpd_pkg::DP_SET_SO: so_ff <= cpd_pkg::OFFSET_BASE - prod;
         cpd_pkg::DP_SUM:    dist_ff <= dist_sum;
         cpd_pkg::DP_FAR:    dist_ff <= cpd_pkg::FAR_DIST;
         cpd_pkg::DP_REPORT: begin
            rep_min_ff  <= min_ff;
            rep_max_ff  <= max_ff;
            rep_park_ff <= park_ff;
         end
         cpd_pkg::DP_OUT: begin
            rsp_data_ff.distance       <= dist_ff;
            rsp_data_ff.echo_count     <= echo_ff;
            rsp_data_ff.report_min     <= rep_min_ff;
            rsp_data_ff.report_max     <= rep_max_ff;
            rsp_data_ff.report_park    <= rep_park_ff;
            rsp_data_ff.in_calibration <= cal_ff;
         end
         default: ;
      endcase
   end

   assign status.rsq_done = rsq_done;
   assign status.div_done = div_done;
   assign status.near     = c_ff[16] || (c_ff == 17'sd0);
   assign status.degen    = p_ff[16] || (p_ff == 17'sd0) || m_ff[16] || (m_ff == 17'sd0);
   assign status.den_zero = (den == 33'sd0);
   assign status.item_cmd = cmd_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/cpd_ctrl.sv @@
`timescale 1ns / 1ps
module cpd_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  cpd_pkg::dp_status_type   status,
   output cpd_pkg::dp_op_type       op
);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_FAR,
      ST_RSQ_C,
      ST_WAIT_C,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_SUM,
      ST_FIT_PREP,
      ST_FIT_CHK,
      ST_DEGEN,
      ST_RSQ_M,
      ST_WAIT_M,
      ST_RSQ_P,
      ST_WAIT_P,
      ST_DEN_CHK,
      ST_DIV,
      ST_WAIT_DIV,
      ST_SET_SF,
      ST_SET_SO,
      ST_FIT_END,
      ST_OUT
   } state_type;

   state_type state_ff;
   logic      boot_ff;
   logic      fitting;

   assign fitting   = boot_ff || (status.item_cmd != cpd_pkg::ITEM_SAMPLE);
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      case (state_ff)
         ST_IDLE:     op = req_valid ? cpd_pkg::DP_LOAD : cpd_pkg::DP_IDLE;
         ST_FAR:      op = cpd_pkg::DP_FAR;
         ST_RSQ_C:    op = cpd_pkg::DP_RSQ_C;
         ST_MUL0:     op = cpd_pkg::DP_MUL0;
         ST_MUL1:     op = cpd_pkg::DP_MUL1;
         ST_MUL2:     op = cpd_pkg::DP_MUL2;
         ST_SUM:      op = cpd_pkg::DP_SUM;
         ST_FIT_PREP: op = cpd_pkg::DP_FIT_PREP;
         ST_DEGEN:    op = cpd_pkg::DP_DEGEN;
         ST_RSQ_M:    op = cpd_pkg::DP_RSQ_M;
         ST_WAIT_M:   op = status.rsq_done ? cpd_pkg::DP_SAVE_RM : cpd_pkg::DP_IDLE;
         ST_RSQ_P:    op = cpd_pkg::DP_RSQ_P;
         ST_DIV:      op = cpd_pkg::DP_DIV;
         ST_SET_SF:   op = cpd_pkg::DP_SET_SF;
         ST_SET_SO:   op = cpd_pkg::DP_SET_SO;
         ST_FIT_END: begin
            if (boot_ff)                                       op = cpd_pkg::DP_IDLE;
            else if (status.item_cmd == cpd_pkg::ITEM_RESTORE) op = cpd_pkg::DP_REPORT;
            else if (status.item_cmd == cpd_pkg::ITEM_END)     op = cpd_pkg::DP_END_CAL;
            else                                               op = cpd_pkg::DP_IDLE;
         end
         ST_OUT:      op = status.out_free ? cpd_pkg::DP_OUT : cpd_pkg::DP_IDLE;
         default:     op = cpd_pkg::DP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FIT_PREP;
         boot_ff  <= 1'b1;
      end else begin
         case (state_ff)
            ST_IDLE:     if (req_valid) state_ff <= ST_DISPATCH;
            ST_DISPATCH: begin
               case (status.item_cmd)
                  cpd_pkg::ITEM_SAMPLE: state_ff <= status.near ? ST_FAR : ST_RSQ_C;
                  cpd_pkg::ITEM_BEGIN:  state_ff <= ST_OUT;
                  default:              state_ff <= ST_FIT_PREP;
               endcase
            end
            ST_FAR:      state_ff <= ST_OUT;
            ST_RSQ_C:    state_ff <= ST_WAIT_C;
            ST_WAIT_C:   if (status.rsq_done) state_ff <= ST_MUL0;
            ST_MUL0:     state_ff <= ST_MUL1;
            ST_MUL1:     state_ff <= ST_MUL2;
            ST_MUL2:     state_ff <= fitting ? ST_SET_SO : ST_SUM;
            ST_SUM:      state_ff <= ST_OUT;
            ST_FIT_PREP: state_ff <= ST_FIT_CHK;
            ST_FIT_CHK:  state_ff <= status.degen ? ST_DEGEN : ST_RSQ_M;
            ST_DEGEN:    state_ff <= ST_FIT_END;
            ST_RSQ_M:    state_ff <= ST_WAIT_M;
            ST_WAIT_M:   if (status.rsq_done) state_ff <= ST_RSQ_P;
            ST_RSQ_P:    state_ff <= ST_WAIT_P;
            ST_WAIT_P:   if (status.rsq_done) state_ff <= ST_DEN_CHK;
            ST_DEN_CHK:  state_ff <= status.den_zero ? ST_DEGEN : ST_DIV;
            ST_DIV:      state_ff <= ST_WAIT_DIV;
            ST_WAIT_DIV: if (status.div_done) state_ff <= ST_SET_SF;
            ST_SET_SF:   state_ff <= ST_MUL0;
            ST_SET_SO:   state_ff <= ST_FIT_END;
            ST_FIT_END: begin
               boot_ff  <= 1'b0;
               state_ff <= boot_ff ? ST_IDLE : ST_OUT;
            end
            ST_OUT:      if (status.out_free) state_ff <= ST_IDLE;
            default:     state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

@@ rtl/calibrated_proximity_to_distance_unit.sv @@
`timescale 1ns / 1ps
// Proximity count to distance converter with min/max/park calibration.
// req channel: command (sample, begin, end, restore calibration) and raw_count;
// one transaction on rsp per request, in order, carrying distance, the echoed
// count, the current min/max/park counts and the calibration flag.
// csr port: write-only saved min/max/park counts, used by the restore command.
// One request in flight at a time; req_stall is high from acceptance until
// the result is loaded into the output register, and the next request can be
// taken in the cycle after that load.
// A sample runs a 32-step reciprocal root, then a 64x32 multiply in two
// 32x32 passes; a count at or below the offset skips both, as does begin.
// End and restore refit the curve: two roots and a 63-step divide, with a
// shorter path when the counts are degenerate or the denominator is zero.
// Reset clears state and runs the same fit on the default counts; req_stall
// stays high until that fit ends. The output register frees as soon as its
// transaction completes; if rsp_stall holds, the next result waits in the
// datapath and requests are held off until it can be loaded.
module calibrated_proximity_to_distance_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  cpd_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output cpd_pkg::rsp_type   rsp_data,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   cpd_pkg::dp_op_type     op;
   cpd_pkg::dp_status_type status;

   cpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .op        (op)
   );

   cpd_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .status    (status),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/cpd_checker.sv @@
`timescale 1ns / 1ps
module cpd_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input cpd_pkg::rsp_type   rsp_data
);

   // curve fit runs out of reset before any request is taken
   a_boot_busy: assert property (@(posedge clock) reset |=> req_stall)
      else $error("request taken during power-up fit");

   // one request in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second request taken while busy");

   // a new result only appears when the block was working
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without work in progress");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind calibrated_proximity_to_distance_unit cpd_checker u_cpd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
